[hdl/dfr_pkg.sv]
// shared types and constants for the marker / length / checksum deframer
`timescale 1ns / 1ps
`default_nettype none

package dfr_pkg;

    localparam int BUFFER_DEPTH_DEF = 128;
    localparam int MARKER_LEN       = 5;
    localparam int PAYLOAD_BASE     = 6;

    localparam logic [7:0] MARKER_SEQ [MARKER_LEN] = '{8'h73, 8'h74, 8'h61, 8'h72, 8'h74};

    typedef enum logic [2:0] {
        EV_HUNT     = 3'd0,
        EV_LENGTH   = 3'd1,
        EV_PAYLOAD  = 3'd2,
        EV_GOOD     = 3'd3,
        EV_BAD_SUM  = 3'd4,
        EV_ABORT    = 3'd5,
        EV_RELEASE  = 3'd6
    } t_event;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        t_event     event_res;
        logic [7:0] payload_byte;
        logic [6:0] payload_index;
        logic [7:0] frame_length;
    } t_result;

endpackage

`default_nettype wire

[hdl/dfr_in_reg.sv]
// input register stage of the deframer
`timescale 1ns / 1ps
`default_nettype none

module dfr_in_reg (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire dfr_pkg::t_item i_item,
    output logic             o_valid,
    input  wire              i_advance,
    output dfr_pkg::t_item   o_item
);

    logic           r_valid;
    dfr_pkg::t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

[hdl/dfr_step.sv]
// frame state registers and per-byte update logic
`timescale 1ns / 1ps
`default_nettype none

module dfr_step #(
    parameter int BUFFER_DEPTH = dfr_pkg::BUFFER_DEPTH_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_fire,
    input  wire dfr_pkg::t_item i_item,
    output dfr_pkg::t_result    o_result
);

    localparam logic [7:0] DEPTH = 8'(BUFFER_DEPTH);
    localparam logic [7:0] BASE  = 8'(dfr_pkg::PAYLOAD_BASE);
    localparam logic [7:0] MLEN  = 8'(dfr_pkg::MARKER_LEN);

    logic [7:0] r_position, n_position;
    logic [7:0] r_length,   n_length;
    logic [7:0] r_sum,      n_sum;

    logic [8:0] w_end;
    logic [9:0] w_end_next;
    logic [7:0] w_off;
    logic [7:0] w_byte;

    always_comb begin
        w_byte     = i_item.rx_byte;
        w_end      = {1'b0, r_length} + 9'(dfr_pkg::PAYLOAD_BASE);
        w_end_next = {1'b0, w_end} + 10'd1;
        w_off      = r_position - BASE;

        n_position = r_position;
        n_length   = r_length;
        n_sum      = r_sum;
        o_result.event_res     = dfr_pkg::EV_HUNT;
        o_result.payload_byte  = '0;
        o_result.payload_index = '0;

        if (i_item.mode) begin
            n_position         = '0;
            o_result.event_res = dfr_pkg::EV_RELEASE;
        end else if (r_position < MLEN) begin
            if (w_byte == dfr_pkg::MARKER_SEQ[r_position[2:0]]) begin
                n_position = r_position + 8'd1;
            end else begin
                n_position = '0;
            end
        end else if (r_position == MLEN) begin
            n_length           = w_byte;
            n_sum              = '0;
            n_position         = BASE;
            o_result.event_res = dfr_pkg::EV_LENGTH;
        end else if (({1'b0, r_position} < w_end) && (w_off < DEPTH)) begin
            n_sum                  = r_sum + w_byte;
            n_position             = r_position + 8'd1;
            o_result.event_res     = dfr_pkg::EV_PAYLOAD;
            o_result.payload_byte  = w_byte;
            o_result.payload_index = w_off[6:0];
        end else if ({1'b0, r_position} == w_end) begin
            if (w_byte == r_sum) begin
                n_position         = r_position + 8'd1;
                o_result.event_res = dfr_pkg::EV_GOOD;
            end else begin
                n_position         = '0;
                o_result.event_res = dfr_pkg::EV_BAD_SUM;
            end
        end else begin
            // byte after an accepted frame is dropped quietly; any other byte here reports an abort
            n_position = '0;
            if ({2'b00, r_position} != w_end_next) begin
                o_result.event_res = dfr_pkg::EV_ABORT;
            end
        end

        o_result.frame_length = n_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_length   <= '0;
            r_sum      <= '0;
        end else if (i_fire) begin
            r_position <= n_position;
            r_length   <= n_length;
            r_sum      <= n_sum;
        end
    end

endmodule

`default_nettype wire

[hdl/dfr_out_reg.sv]
// result register stage of the deframer
`timescale 1ns / 1ps
`default_nettype none

module dfr_out_reg (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_free,
    input  wire dfr_pkg::t_result i_result,
    output logic                  o_valid,
    input  wire                   i_ready,
    output dfr_pkg::t_result      o_result
);

    logic             r_valid;
    dfr_pkg::t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_free) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

[hdl/marker_length_checksum_deframer.sv]
// top level of the marker / length / checksum deframer
// path from input transfer to result transfer: input register, then result register
// throughput: one byte per cycle unless the consumer stalls; state update sits between the registers
// both stages hold while the consumer stalls; a new byte enters as soon as a stage frees up
// reset: synchronous active-low i_rst_n clears stage valids and the frame state to zero
`timescale 1ns / 1ps
`default_nettype none

module marker_length_checksum_deframer #(
    parameter int BUFFER_DEPTH = dfr_pkg::BUFFER_DEPTH_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  wire        i_mode,
    input  wire  [7:0] i_rx_byte,
    output logic       o_valid,
    input  wire        i_ready,
    output logic [2:0] o_event_res,
    output logic [7:0] o_payload_byte,
    output logic [6:0] o_payload_index,
    output logic [7:0] o_frame_length
);

    dfr_pkg::t_item   w_in_item;
    dfr_pkg::t_item   w_stage_item;
    dfr_pkg::t_result w_step_result;
    dfr_pkg::t_result w_out_result;
    logic             w_stage_valid;
    logic             w_out_free;
    logic             w_fire;

    assign w_in_item.mode    = i_mode;
    assign w_in_item.rx_byte = i_rx_byte;
    assign w_fire            = w_stage_valid && w_out_free;

    dfr_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (w_in_item),
        .o_valid   (w_stage_valid),
        .i_advance (w_fire),
        .o_item    (w_stage_item)
    );

    dfr_step #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (w_stage_item),
        .o_result (w_step_result)
    );

    dfr_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_stage_valid),
        .o_free   (w_out_free),
        .i_result (w_step_result),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (w_out_result)
    );

    assign o_event_res     = w_out_result.event_res;
    assign o_payload_byte  = w_out_result.payload_byte;
    assign o_payload_index = w_out_result.payload_index;
    assign o_frame_length  = w_out_result.frame_length;

endmodule

`default_nettype wire

[sim/tb.sv]
// testbench for the marker / length / checksum deframer with a built-in frame predictor
`timescale 1ns / 1ps

module tb;

    localparam int BUFFER_DEPTH = dfr_pkg::BUFFER_DEPTH_DEF;
    localparam int QUIET_LIMIT  = 1000;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic       i_mode    = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_ready   = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [2:0] o_event_res;
    logic [7:0] o_payload_byte;
    logic [6:0] o_payload_index;
    logic [7:0] o_frame_length;

    // predicted frame state
    logic [7:0] hunt_pos  = 8'd0;
    logic [7:0] frame_len = 8'd0;
    logic [7:0] frame_sum = 8'd0;

    dfr_pkg::t_result expected_events [$];
    int      mismatches      = 0;
    int      bytes_sent      = 0;
    int      frames_sent     = 0;
    int      results_checked = 0;
    int      event_seen [8];
    int      stall_left      = 0;
    int      quiet_cycles    = 0;
    bit      src_idle        = 1'b0;
    bit      snk_idle        = 1'b0;

    marker_length_checksum_deframer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_event_res     (o_event_res),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index),
        .o_frame_length  (o_frame_length)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic dfr_pkg::t_result deframe_step(input logic m, input logic [7:0] b);
        dfr_pkg::t_result r;
        int unsigned      p;
        int unsigned      frame_end;
        r = '0;
        p = hunt_pos;
        frame_end = int'(frame_len) + dfr_pkg::PAYLOAD_BASE;
        if (m) begin
            hunt_pos = 8'd0;
            r.event_res = dfr_pkg::EV_RELEASE;
        end else if (p < dfr_pkg::MARKER_LEN) begin
            hunt_pos = (b == dfr_pkg::MARKER_SEQ[p]) ? hunt_pos + 8'd1 : 8'd0;
            r.event_res = dfr_pkg::EV_HUNT;
        end else if (p == dfr_pkg::MARKER_LEN) begin
            frame_len = b;
            frame_sum = 8'd0;
            hunt_pos = 8'(dfr_pkg::PAYLOAD_BASE);
            r.event_res = dfr_pkg::EV_LENGTH;
        end else if (p < frame_end && (p - dfr_pkg::PAYLOAD_BASE) < BUFFER_DEPTH) begin
            frame_sum = frame_sum + b;
            r.payload_byte = b;
            r.payload_index = 7'(p - dfr_pkg::PAYLOAD_BASE);
            hunt_pos = hunt_pos + 8'd1;
            r.event_res = dfr_pkg::EV_PAYLOAD;
        end else if (p == frame_end) begin
            if (b == frame_sum) begin
                hunt_pos = hunt_pos + 8'd1;
                r.event_res = dfr_pkg::EV_GOOD;
            end else begin
                hunt_pos = 8'd0;
                r.event_res = dfr_pkg::EV_BAD_SUM;
            end
        end else begin
            if (p == frame_end + 1) begin
                r.event_res = dfr_pkg::EV_HUNT;
            end else begin
                r.event_res = dfr_pkg::EV_ABORT;
            end
            hunt_pos = 8'd0;
        end
        r.frame_length = frame_len;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        dfr_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_events.size() == 0) begin
                report_mismatch("result with nothing pending", 8'(o_event_res), 8'hxx);
            end else begin
                want = expected_events.pop_front();
                if (o_event_res !== want.event_res)
                    report_mismatch("event", 8'(o_event_res), 8'(want.event_res));
                if (o_payload_byte !== want.payload_byte)
                    report_mismatch("payload byte", o_payload_byte, want.payload_byte);
                if (o_payload_index !== want.payload_index)
                    report_mismatch("payload index", 8'(o_payload_index),
                                    8'(want.payload_index));
                if (o_frame_length !== want.frame_length)
                    report_mismatch("frame length", o_frame_length, want.frame_length);
                event_seen[want.event_res]++;
                results_checked++;
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (snk_idle && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // watchdog on transfers
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic send_item(input logic m, input logic [7:0] b);
        int unsigned gap;
        if (src_idle && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 18);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_mode    <= m;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_events.push_back(deframe_step(m, b));
        bytes_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_byte();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 8'h00;
        if (sel == 1) return 8'hff;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_length();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 75) return 8'($urandom_range(0, 10));
        if (sel < 90) return 8'($urandom_range(11, 127));
        if (sel < 95) return 8'(BUFFER_DEPTH);
        return 8'($urandom_range(129, 255));
    endfunction

    // full frame; a release replaces payload byte cut_at when it lies inside the frame
    task automatic send_frame(input logic [7:0] len, input bit sum_ok, input int cut_at);
        logic [7:0] sum;
        logic [7:0] b;
        int         k;
        sum = 8'd0;
        for (k = 0; k < dfr_pkg::MARKER_LEN; k++) send_item(1'b0, dfr_pkg::MARKER_SEQ[k]);
        send_item(1'b0, len);
        for (k = 0; k < int'(len) && k < BUFFER_DEPTH; k++) begin
            if (k == cut_at) begin
                send_item(1'b1, 8'($urandom));
                return;
            end
            b = rand_byte();
            sum = sum + b;
            send_item(1'b0, b);
        end
        if (len > BUFFER_DEPTH) send_item(1'b0, rand_byte());
        else send_item(1'b0, sum_ok ? sum : sum ^ 8'($urandom_range(1, 255)));
        frames_sent++;
    endtask

    task automatic test_marker_hunt();
        // a repeated first marker byte is not taken as a fresh start
        send_item(1'b0, "s");
        send_item(1'b0, "s");
        send_item(1'b0, "t");
        send_item(1'b0, "a");
        send_item(1'b0, "r");
        send_item(1'b0, "t");
        send_item(1'b0, 8'h00);
        send_item(1'b0, "s");
        send_item(1'b0, "t");
        send_item(1'b1, 8'hff);
        send_item(1'b0, 8'hff);
    endtask

    task automatic test_short_frames();
        int k;
        // good two-byte frame, then the discarded byte after it
        for (k = 0; k < dfr_pkg::MARKER_LEN; k++) send_item(1'b0, dfr_pkg::MARKER_SEQ[k]);
        send_item(1'b0, 8'd2);
        send_item(1'b0, 8'hff);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hff);
        send_item(1'b0, 8'h73);
        // empty frame with a wrong checksum
        for (k = 0; k < dfr_pkg::MARKER_LEN; k++) send_item(1'b0, dfr_pkg::MARKER_SEQ[k]);
        send_item(1'b0, 8'd0);
        send_item(1'b0, 8'h01);
        frames_sent += 2;
    endtask

    task automatic test_buffer_limit();
        send_frame(8'(BUFFER_DEPTH), 1'b1, -1);
        send_item(1'b0, rand_byte());
        send_frame(8'hff, 1'b1, -1);
        send_frame(8'(BUFFER_DEPTH + 1), 1'b1, -1);
    endtask

    task automatic test_random_traffic(input int target, input bit allow_idle);
        int unsigned sel;
        int          n;
        int          k;
        logic [7:0]  len;
        while (bytes_sent < target) begin
            src_idle = allow_idle && $urandom_range(0, 3) != 0;
            snk_idle = allow_idle && $urandom_range(0, 3) != 0;
            sel = $urandom_range(0, 99);
            if (sel < 65) begin
                send_frame(pick_length(), $urandom_range(0, 4) != 0, -1);
                if ($urandom_range(0, 1)) send_item(1'b0, rand_byte());
            end else if (sel < 75) begin
                len = pick_length();
                send_frame(len, 1'b1, $urandom_range(0, len));
            end else if (sel < 85) begin
                n = $urandom_range(1, dfr_pkg::MARKER_LEN - 1);
                for (k = 0; k < n; k++) send_item(1'b0, dfr_pkg::MARKER_SEQ[k]);
                send_item(1'b0, rand_byte());
            end else if (sel < 95) begin
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++) send_item($urandom_range(0, 4) == 0, 8'($urandom));
            end else begin
                send_item(1'b1, 8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        src_idle = 1'b1;
        snk_idle = 1'b1;
        test_marker_hunt();
        wait_drained();
        test_short_frames();
        wait_drained();
        test_buffer_limit();
        wait_drained();
        test_random_traffic(1300, 1'b1);
        test_random_traffic(1450, 1'b0);
        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("covered %0d bytes and %0d frames, %0d results checked",
                 bytes_sent, frames_sent, results_checked);
        $display("events: %0d good, %0d bad checksum, %0d aborted, %0d released",
                 event_seen[dfr_pkg::EV_GOOD], event_seen[dfr_pkg::EV_BAD_SUM],
                 event_seen[dfr_pkg::EV_ABORT], event_seen[dfr_pkg::EV_RELEASE]);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
